// File: sv/http_gzip_coding_header_scan_assert.svh
// assertion macros for the header scan back end
// expects signals named clk and rst in the including module
`ifndef HTTP_GZIP_CODING_HEADER_SCAN_ASSERT_SVH
`define HTTP_GZIP_CODING_HEADER_SCAN_ASSERT_SVH

`ifndef SYNTHESIS

`define HGZS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("header scan check failed");

`define HGZS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("header scan check failed");

`else

`define HGZS_ASSERT_IMP(label, ante, cons)
`define HGZS_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: sv/hgzs_pkg.sv
// shared types, character constants and scan-step functions for the header scan
// no dependencies
package hgzs_pkg;

  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_LIST   = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;

  localparam logic [4:0] PREFIX_LEN  = 5'd17;
  localparam logic [2:0] TOKEN_DEPTH = 3'd6;
  localparam logic [2:0] GZ_LEN      = 3'd4;
  localparam logic [2:0] XG_LEN      = 3'd6;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // one queued request: optional held cr, optional byte, line end, buffer end
  typedef struct packed {
    logic       do_cr;
    logic       do_byte;
    logic       do_eol;
    logic       last;
    logic [7:0] data;
  } rec_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [4:0] count;
    logic       active;
    logic [2:0] len;
    logic       blank;
    logic       spoiled;
    logic       gz_ok;
    logic       xg_ok;
    logic       found;
  } scan_t;

  localparam scan_t SCAN_RESET = '{
    phase: PH_PREFIX, count: 5'd0, active: 1'b0, len: 3'd0, blank: 1'b0,
    spoiled: 1'b0, gz_ok: 1'b0, xg_ok: 1'b0, found: 1'b0
  };

  function automatic logic [7:0] fold(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic [7:0] prefix_char(logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0:    r = "c";
      5'd1:    r = "o";
      5'd2:    r = "n";
      5'd3:    r = "t";
      5'd4:    r = "e";
      5'd5:    r = "n";
      5'd6:    r = "t";
      5'd7:    r = "-";
      5'd8:    r = "e";
      5'd9:    r = "n";
      5'd10:   r = "c";
      5'd11:   r = "o";
      5'd12:   r = "d";
      5'd13:   r = "i";
      5'd14:   r = "n";
      5'd15:   r = "g";
      5'd16:   r = ":";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] gz_char(logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = "g";
      3'd1:    r = "z";
      3'd2:    r = "i";
      3'd3:    r = "p";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xg_char(logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = "x";
      3'd1:    r = "-";
      3'd2:    r = "g";
      3'd3:    r = "z";
      3'd4:    r = "i";
      3'd5:    r = "p";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic scan_t clear_token(scan_t s);
    scan_t r;
    r = s;
    r.active  = 1'b0;
    r.len     = 3'd0;
    r.blank   = 1'b0;
    r.spoiled = 1'b0;
    return r;
  endfunction

  function automatic scan_t finish_token(scan_t s);
    scan_t r;
    r = s;
    if (s.phase == PH_LIST && !s.spoiled &&
        ((s.len == GZ_LEN && s.gz_ok) || (s.len == XG_LEN && s.xg_ok))) r.found = 1'b1;
    return clear_token(r);
  endfunction

  function automatic scan_t end_line(scan_t s);
    scan_t r;
    r = finish_token(s);
    r.phase = PH_PREFIX;
    r.count = 5'd0;
    return r;
  endfunction

  // one byte through the line matcher
  function automatic scan_t scan_feed(scan_t s, logic [7:0] c);
    scan_t r;
    logic [7:0] f;
    r = s;
    f = fold(c);
    case (s.phase)
      PH_PREFIX: begin
        if (f == prefix_char(s.count)) begin
          r.count = s.count + 5'd1;
          if (s.count == PREFIX_LEN - 5'd1) begin
            r.phase = PH_LIST;
            r = clear_token(r);
          end
        end else begin
          r.phase = PH_SKIP;
        end
      end
      PH_LIST: begin
        if (c == CH_COMMA) begin
          r = finish_token(s);
        end else if (c == CH_SPACE || c == CH_TAB) begin
          if (s.active) r.blank = 1'b1;
        end else begin
          r.active = 1'b1;
          if (s.blank || s.len >= TOKEN_DEPTH) begin
            r.spoiled = 1'b1;
          end else begin
            // running compare against both words instead of keeping the text
            r.gz_ok = (s.len == 3'd0 || s.gz_ok) && s.len < GZ_LEN && f == gz_char(s.len);
            r.xg_ok = (s.len == 3'd0 || s.xg_ok) && f == xg_char(s.len);
            r.len   = s.len + 3'd1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

// File: sv/hgzs_front.sv
// front end: takes header bytes, resolves carriage return holding, builds requests
// depends on hgzs_pkg
module hgzs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         header_byte,
  input  logic               byte_present,
  input  logic               last_byte,
  input  logic               q_full,
  output logic               push,
  output hgzs_pkg::rec_t     push_rec
);
  import hgzs_pkg::*;

  logic held_return;
  logic held_return_next;
  logic accept;
  logic is_cr;
  logic is_lf;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_cr    = byte_present && header_byte == CH_CR;
  assign is_lf    = byte_present && header_byte == CH_LF;

  always_comb begin
    push_rec.data    = header_byte;
    push_rec.last    = last_byte;
    push_rec.do_eol  = is_lf;
    // a held cr becomes a real byte when a byte other than a line feed follows it
    push_rec.do_cr   = held_return && byte_present && !is_lf;
    push_rec.do_byte = byte_present && !is_cr && !is_lf;
    held_return_next = held_return;
    if (byte_present) held_return_next = is_cr;
    if (last_byte) held_return_next = 1'b0;
  end

  assign push = accept &&
                (push_rec.do_cr || push_rec.do_byte || push_rec.do_eol || push_rec.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_return <= 1'b0;
    end else if (accept) begin
      held_return <= held_return_next;
    end
  end

endmodule

// File: sv/hgzs_queue.sv
// two-entry request queue between front and back end
// depends on hgzs_pkg
module hgzs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hgzs_pkg::rec_t push_rec,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output hgzs_pkg::rec_t head
);
  import hgzs_pkg::*;

  rec_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: sv/hgzs_back.sv
// back end: runs the line and coding matcher on queued requests, holds the result
// depends on hgzs_pkg and the assertion macro header
`include "http_gzip_coding_header_scan_assert.svh"

module hgzs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  hgzs_pkg::rec_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           gzip_announced
);
  import hgzs_pkg::*;

  scan_t st;
  scan_t st_next;
  scan_t s_cr;
  scan_t s_byte;
  scan_t s_end;

  assign pop = !empty && (!head.last || !out_valid || !out_stall);

  always_comb begin
    s_cr   = head.do_cr ? scan_feed(st, CH_CR) : st;
    s_byte = head.do_byte ? scan_feed(s_cr, head.data) : s_cr;
    s_end  = (head.do_eol || head.last) ? end_line(s_byte) : s_byte;
    st_next = head.last ? SCAN_RESET : s_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= SCAN_RESET;
      out_valid <= 1'b0;
    end else begin
      if (pop) st <= st_next;
      if (pop && head.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) gzip_announced <= s_end.found;
  end

  `HGZS_ASSERT_IMP(a_prefix_bound, st.phase == PH_PREFIX, st.count < PREFIX_LEN)
  `HGZS_ASSERT_IMP(a_token_bound, 1'b1, st.len <= TOKEN_DEPTH)
  `HGZS_ASSERT_NXT(a_buffer_end_clears, pop && head.last,
                   st.phase == PH_PREFIX && st.count == 5'd0 && !st.found && out_valid)

endmodule

// File: sv/http_gzip_coding_header_scan.sv
// Content-Encoding gzip scanner over a response header buffer, one byte per cycle when
// neither side stalls: the front end takes a byte every clock while the queue is not
// full and the back end's matcher retires one queued request per clock while the queue
// holds one and no result waits on out_stall. A result is registered in the output
// register when its buffer-end request is popped from the queue; a two-entry queue
// between the ends and the output register let either side stall.
// Depends on hgzs_pkg, hgzs_front, hgzs_queue and hgzs_back.
module http_gzip_coding_header_scan (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] header_byte,
  input  logic       byte_present,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       gzip_announced
);
  import hgzs_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  rec_t push_rec;
  rec_t head;

  hgzs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .header_byte  (header_byte),
    .byte_present (byte_present),
    .last_byte    (last_byte),
    .q_full       (full),
    .push         (push),
    .push_rec     (push_rec)
  );

  hgzs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  hgzs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .gzip_announced (gzip_announced)
  );

endmodule

// File: test/http_gzip_coding_header_scan_tb.sv
// testbench for the content-encoding gzip header scanner
// drives byte requests with random gaps and checks every result against its own scan model
// depends on hgzs_pkg and http_gzip_coding_header_scan
`timescale 1ns / 1ps

module http_gzip_coding_header_scan_tb;
  import hgzs_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int IDLE_PCT    = 27;
  localparam int WATCH_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  localparam logic [8*17-1:0] ENC_PREFIX = "content-encoding:";
  localparam logic [47:0]     WORD_GZIP  = 48'h0000_677a_6970;  // "gzip"
  localparam logic [47:0]     WORD_XGZIP = "x-gzip";

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } header_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] header_byte = 8'h00;
  logic       byte_present = 1'b0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       gzip_announced;

  header_req_t request_q[$];
  logic        announced_q[$];
  logic [7:0]  line_buf[$];

  int cycle_n = 0;
  int idle_cycles = 0;
  int errors = 0;
  int n_buffers = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_gzip = 0;
  logic want;
  logic quiet;

  // scan model state
  logic [1:0] scan_phase;
  logic [4:0] prefix_seen;
  logic       in_coding;
  logic [7:0] coding_text [0:5];
  logic [2:0] coding_len;
  logic       coding_blank;
  logic       cr_pending;
  logic       coding_bad;
  logic       gzip_seen;

  http_gzip_coding_header_scan dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .header_byte    (header_byte),
    .byte_present   (byte_present),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .gzip_announced (gzip_announced)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_n <= cycle_n + 1;

  // long stretch with no gaps on either side
  assign quiet = (cycle_n >= 1200 && cycle_n < 2000);

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic coding_equals(input logic [47:0] w, input int n);
    logic ok;
    ok = (int'(coding_len) == n);
    for (int i = 0; i < n; i++)
      if (ok && to_lower(coding_text[i]) != w[8*(n-1-i) +: 8]) ok = 1'b0;
    return ok;
  endfunction

  task automatic reset_scan();
    scan_phase   = PH_PREFIX;
    prefix_seen  = 5'd0;
    in_coding    = 1'b0;
    coding_len   = 3'd0;
    coding_blank = 1'b0;
    cr_pending   = 1'b0;
    coding_bad   = 1'b0;
    gzip_seen    = 1'b0;
    for (int i = 0; i < 6; i++) coding_text[i] = 8'h00;
  endtask

  task automatic clear_coding();
    in_coding    = 1'b0;
    coding_len   = 3'd0;
    coding_blank = 1'b0;
    coding_bad   = 1'b0;
  endtask

  task automatic close_coding();
    if (scan_phase == PH_LIST && !coding_bad &&
        (coding_equals(WORD_GZIP, 4) || coding_equals(WORD_XGZIP, 6)))
      gzip_seen = 1'b1;
    clear_coding();
  endtask

  task automatic close_line();
    close_coding();
    scan_phase  = PH_PREFIX;
    prefix_seen = 5'd0;
  endtask

  task automatic scan_byte(input logic [7:0] c);
    case (scan_phase)
      PH_PREFIX: begin
        if (prefix_seen < PREFIX_LEN &&
            to_lower(c) == ENC_PREFIX[8*(16 - int'(prefix_seen)) +: 8]) begin
          prefix_seen = prefix_seen + 5'd1;
          if (prefix_seen == PREFIX_LEN) begin
            scan_phase = PH_LIST;
            clear_coding();
          end
        end else begin
          scan_phase = PH_SKIP;
        end
      end
      PH_LIST: begin
        if (c == CH_COMMA) begin
          close_coding();
        end else if (c == CH_SPACE || c == CH_TAB) begin
          if (in_coding) coding_blank = 1'b1;
        end else begin
          in_coding = 1'b1;
          if (coding_blank || coding_len >= TOKEN_DEPTH) begin
            coding_bad = 1'b1;
          end else begin
            coding_text[coding_len] = c;
            coding_len = coding_len + 3'd1;
          end
        end
      end
      default: ;
    endcase
  endtask

  // a cr is held until the next byte shows whether it ends the line
  task automatic take_request(input logic [7:0] c, input logic present, input logic last);
    if (present) begin
      if (c == CH_CR) begin
        if (cr_pending) scan_byte(CH_CR);
        cr_pending = 1'b1;
      end else if (c == CH_LF) begin
        cr_pending = 1'b0;
        close_line();
      end else begin
        if (cr_pending) begin
          scan_byte(CH_CR);
          cr_pending = 1'b0;
        end
        scan_byte(c);
      end
    end
    if (last) begin
      cr_pending = 1'b0;
      close_line();
      announced_q.push_back(gzip_seen);
      reset_scan();
    end
  endtask

  // stimulus building
  task automatic add_req(input logic [7:0] c, input logic present, input logic last);
    header_req_t r;
    r.data    = c;
    r.present = present;
    r.last    = last;
    request_q.push_back(r);
  endtask

  task automatic add_text(input string s, input int upto);
    logic [7:0] c;
    for (int i = 0; i < s.len() && i < upto; i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
      line_buf.push_back(c);
    end
  endtask

  task automatic add_blanks(input int max_n);
    int n;
    n = $urandom_range(0, max_n);
    for (int i = 0; i < n; i++) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic add_random(input int max_n, input bit printable);
    int n;
    n = $urandom_range(0, max_n);
    for (int i = 0; i < n; i++)
      line_buf.push_back(printable ? 8'($urandom_range(32, 126)) : 8'($urandom));
  endtask

  task automatic add_coding();
    add_blanks(2);
    case ($urandom_range(0, 11))
      0, 1, 2: add_text("gzip", 99);
      3, 4:    add_text("x-gzip", 99);
      5:       add_text("deflate", 99);
      6:       ;
      7:       add_text("gzipx", 99);
      8:       add_text("x-gz", 99);
      9:       add_text("gz ip", 99);
      10: begin
        add_text("gzip", 99);
        line_buf.push_back(CH_CR);
      end
      default: add_random(7, 1'b0);
    endcase
    add_blanks(2);
  endtask

  task automatic add_line(input bit final_line);
    int kind;
    int mode;
    int start;
    int ncod;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      start = line_buf.size();
      mode  = $urandom_range(0, 19);
      if (mode == 0) begin
        // line ends before the whole prefix
        add_text("content-encoding:", $urandom_range(0, 16));
      end else begin
        add_text("content-encoding:", 17);
        if (mode == 1) line_buf[start + $urandom_range(0, 16)] = 8'($urandom);
        ncod = $urandom_range(1, 3);
        for (int k = 0; k < ncod; k++) begin
          if (k > 0) line_buf.push_back(CH_COMMA);
          add_coding();
        end
        if ($urandom_range(0, 7) == 0) line_buf.push_back(CH_COMMA);
      end
    end else if (kind == 6) begin
      add_text("content-type: text/html", 99);
    end else if (kind == 7) begin
      add_text("content-encod", 99);
      add_random(4, 1'b1);
    end else if (kind == 8) begin
      add_random(20, 1'b1);
    end else begin
      add_random(10, 1'b0);
    end
    if (!final_line) begin
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        line_buf.push_back(CH_CR);
        line_buf.push_back(CH_LF);
      end else if (mode <= 7) begin
        line_buf.push_back(CH_LF);
      end else if (mode == 8) begin
        line_buf.push_back(CH_CR);
        line_buf.push_back(CH_CR);
        line_buf.push_back(CH_LF);
      end else begin
        // lone cr, the line goes on
        line_buf.push_back(CH_CR);
      end
    end else begin
      mode = $urandom_range(0, 2);
      if (mode >= 1) line_buf.push_back(CH_CR);
      if (mode == 2) line_buf.push_back(CH_LF);
    end
  endtask

  task automatic emit_buffer();
    int  n;
    bit  on_byte;
    n = line_buf.size();
    on_byte = (n != 0) && ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) add_req(8'($urandom), 1'b0, 1'b0);
      add_req(line_buf[i], 1'b1, on_byte && (i == n - 1));
    end
    if (!on_byte) add_req(8'($urandom), 1'b0, 1'b1);
    line_buf.delete();
    n_buffers++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        take_request(header_byte, byte_present, last_byte);
        n_requests++;
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          header_byte  <= request_q[0].data;
          byte_present <= request_q[0].present;
          last_byte    <= request_q[0].last;
          in_valid     <= 1'b1;
          void'(request_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (announced_q.size() == 0) begin
          $error("unexpected result, gzip_announced actual %0d", gzip_announced);
          errors++;
        end else begin
          want = announced_q.pop_front();
          if (want) n_gzip++;
          if (gzip_announced !== want) begin
            $error("gzip_announced mismatch: expected %0d actual %0d", want, gzip_announced);
            errors++;
          end
        end
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", WATCH_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_scan();

    // directed: empty buffer, ignored item, extreme bytes, cr at buffer end
    add_req(8'h00, 1'b0, 1'b1);
    add_req(8'hff, 1'b0, 1'b0);
    add_req(8'hff, 1'b1, 1'b1);
    add_req(8'h00, 1'b1, 1'b1);
    add_text("CONTENT-encoding:GZIP", 99);
    line_buf.push_back(CH_CR);
    for (int i = 0; i < line_buf.size(); i++)
      add_req(line_buf[i], 1'b1, i == line_buf.size() - 1);
    line_buf.delete();
    n_buffers = 4;

    while (request_q.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 24) != 0) begin
        for (int k = $urandom_range(1, 3); k > 0; k--) add_line(k == 1);
      end
      emit_buffer();
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (announced_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests in %0d header buffers, %0d results checked (%0d announced gzip)",
             n_requests, n_buffers, n_results, n_gzip);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
